// ----- src/csb_pkg.sv -----
// Shared constants, command codes and controller/datapath handshake types for the cursor buffer.
`timescale 1ns / 1ps

package csb_pkg;

   localparam int CSB_DEPTH  = 64;
   localparam int CSB_WORD_W = 64;
   localparam int CSB_CNT_W  = $clog2(CSB_DEPTH + 1);
   localparam int CSB_ADDR_W = $clog2(CSB_DEPTH);
   localparam int CSB_CODE_W = 4;

   typedef enum logic [CSB_CODE_W-1:0] {
      CODE_START    = 4'd0,
      CODE_END      = 4'd1,
      CODE_ADVANCE  = 4'd2,
      CODE_RETREAT  = 4'd3,
      CODE_INSERT   = 4'd4,
      CODE_ATTACH   = 4'd5,
      CODE_REMOVE   = 4'd6,
      CODE_INSFRONT = 4'd7,
      CODE_APPEND   = 4'd8,
      CODE_RMFRONT  = 4'd9,
      CODE_READIDX  = 4'd10,
      CODE_READCUR  = 4'd11
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SHIFT,
      ST_FINAL,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic load_req;
      logic plan_en;
      logic shift_en;
      logic final_en;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic shift_busy;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- src/csb_controller.sv -----
// Command sequencer: accept, plan, shift loop, final access, response load.
`timescale 1ns / 1ps

module csb_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csb_pkg::dp_status_type status,
   output csb_pkg::ctl_cmd_type   cmd
);
   import csb_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cmd.plan_en = 1'b1;
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.shift_en = 1'b1;
            // busy covers the last pending write-back as well
            if (!status.shift_busy) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_en = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/csb_datapath.sv -----
// Entry memory, count and cursor registers, shift engine and response registers.
`timescale 1ns / 1ps

module csb_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  csb_pkg::ctl_cmd_type             cmd,
   output csb_pkg::dp_status_type           status,
   input  logic [csb_pkg::CSB_CODE_W-1:0]   req_type,
   input  logic [csb_pkg::CSB_WORD_W-1:0]   req_entry_value,
   input  logic [csb_pkg::CSB_ADDR_W-1:0]   req_read_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [csb_pkg::CSB_WORD_W-1:0]   rsp_read_value,
   output logic                             rsp_ok,
   output logic                             rsp_has_current,
   output logic [csb_pkg::CSB_CNT_W-1:0]    rsp_item_count,
   output logic [csb_pkg::CSB_CNT_W-1:0]    rsp_cursor_pos
);
   import csb_pkg::*;

   typedef struct packed {
      logic                  ok;
      logic [CSB_CNT_W-1:0]  n_count;
      logic [CSB_CNT_W-1:0]  n_cursor;
      logic                  up;
      logic                  down;
      logic [CSB_CNT_W-1:0]  from;
      logic                  wr;
      logic [CSB_ADDR_W-1:0] wr_addr;
      logic                  rd;
      logic [CSB_ADDR_W-1:0] rd_addr;
   } plan_type;

   logic [CSB_WORD_W-1:0] mem [CSB_DEPTH];

   logic [CSB_CODE_W-1:0] code_ff;
   logic [CSB_WORD_W-1:0] value_ff;
   logic [CSB_ADDR_W-1:0] index_ff;
   logic [CSB_CNT_W-1:0]  count_ff;
   logic [CSB_CNT_W-1:0]  cursor_ff;
   plan_type              plan_ff, plan_in;
   logic [CSB_CNT_W-1:0]  ptr_ff;
   logic [CSB_WORD_W-1:0] rd_ff;
   logic                  wb_valid_ff;
   logic [CSB_ADDR_W-1:0] wb_addr_ff;
   logic                  rsp_valid_ff;
   logic [CSB_WORD_W-1:0] rsp_value_ff;
   logic                  rsp_ok_ff;
   logic                  rsp_cur_ff;
   logic [CSB_CNT_W-1:0]  rsp_count_ff;
   logic [CSB_CNT_W-1:0]  rsp_cursor_ff;

   logic                  cur_ok;
   logic                  full;
   logic                  empty;
   logic [CSB_CNT_W-1:0]  ins_pos;
   logic [CSB_CNT_W-1:0]  cur_next;
   logic                  shift_todo;
   logic [CSB_CNT_W-1:0]  src;
   logic [CSB_CNT_W-1:0]  ptr_next;
   logic                  step;

   assign cur_ok   = cursor_ff < count_ff;
   assign full     = count_ff == CSB_CNT_W'(CSB_DEPTH);
   assign empty    = count_ff == '0;
   assign ins_pos  = cur_ok ? cursor_ff : '0;
   assign cur_next = cursor_ff + CSB_CNT_W'(1);

   always_comb begin
      plan_in          = '0;
      plan_in.ok       = 1'b1;
      plan_in.n_count  = count_ff;
      plan_in.n_cursor = cursor_ff;
      unique case (code_ff)
         CODE_START: begin
            plan_in.n_cursor = '0;
         end
         CODE_END: begin
            if (empty) plan_in.ok = 1'b0;
            else       plan_in.n_cursor = count_ff - CSB_CNT_W'(1);
         end
         CODE_ADVANCE: begin
            if (cur_ok) plan_in.n_cursor = cur_next;
            else        plan_in.ok = 1'b0;
         end
         CODE_RETREAT: begin
            if (!cur_ok)              plan_in.ok = 1'b0;
            else if (cursor_ff != '0) plan_in.n_cursor = cursor_ff - CSB_CNT_W'(1);
         end
         CODE_INSERT: begin
            if (full) begin
               plan_in.ok = 1'b0;
            end else begin
               plan_in.up       = 1'b1;
               plan_in.from     = ins_pos;
               plan_in.wr       = 1'b1;
               plan_in.wr_addr  = ins_pos[CSB_ADDR_W-1:0];
               plan_in.n_cursor = ins_pos;
               plan_in.n_count  = count_ff + CSB_CNT_W'(1);
            end
         end
         CODE_ATTACH: begin
            if (full) begin
               plan_in.ok = 1'b0;
            end else if (!cur_ok) begin
               plan_in.wr       = 1'b1;
               plan_in.wr_addr  = count_ff[CSB_ADDR_W-1:0];
               plan_in.n_cursor = count_ff;
               plan_in.n_count  = count_ff + CSB_CNT_W'(1);
            end else begin
               plan_in.up       = 1'b1;
               plan_in.from     = cur_next;
               plan_in.wr       = 1'b1;
               plan_in.wr_addr  = cur_next[CSB_ADDR_W-1:0];
               plan_in.n_cursor = cur_next;
               plan_in.n_count  = count_ff + CSB_CNT_W'(1);
            end
         end
         CODE_REMOVE: begin
            if (cur_ok) begin
               plan_in.down    = 1'b1;
               plan_in.from    = cursor_ff;
               plan_in.n_count = count_ff - CSB_CNT_W'(1);
            end else begin
               plan_in.ok = 1'b0;
            end
         end
         CODE_INSFRONT: begin
            if (full) begin
               plan_in.ok = 1'b0;
            end else begin
               plan_in.up       = 1'b1;
               plan_in.from     = '0;
               plan_in.wr       = 1'b1;
               plan_in.wr_addr  = '0;
               plan_in.n_cursor = '0;
               plan_in.n_count  = count_ff + CSB_CNT_W'(1);
            end
         end
         CODE_APPEND: begin
            if (full) begin
               plan_in.ok = 1'b0;
            end else begin
               plan_in.wr       = 1'b1;
               plan_in.wr_addr  = count_ff[CSB_ADDR_W-1:0];
               plan_in.n_cursor = count_ff;
               plan_in.n_count  = count_ff + CSB_CNT_W'(1);
            end
         end
         CODE_RMFRONT: begin
            if (empty) begin
               plan_in.ok = 1'b0;
            end else begin
               plan_in.down     = 1'b1;
               plan_in.from     = '0;
               plan_in.n_cursor = '0;
               plan_in.n_count  = count_ff - CSB_CNT_W'(1);
            end
         end
         CODE_READIDX: begin
            if (CSB_CNT_W'(index_ff) < count_ff) begin
               plan_in.rd      = 1'b1;
               plan_in.rd_addr = index_ff;
            end else begin
               plan_in.ok = 1'b0;
            end
         end
         CODE_READCUR: begin
            if (cur_ok) begin
               plan_in.rd      = 1'b1;
               plan_in.rd_addr = cursor_ff[CSB_ADDR_W-1:0];
            end else begin
               plan_in.ok = 1'b0;
            end
         end
         default: begin
            plan_in.ok = 1'b0;
         end
      endcase
   end

   // ptr is the destination slot; shift up walks downward, shift down walks upward
   always_comb begin
      shift_todo = 1'b0;
      if (plan_ff.up)        shift_todo = ptr_ff > plan_ff.from;
      else if (plan_ff.down) shift_todo = (ptr_ff + CSB_CNT_W'(1)) < count_ff;
   end

   assign src      = plan_ff.up ? ptr_ff - CSB_CNT_W'(1) : ptr_ff + CSB_CNT_W'(1);
   assign ptr_next = src;
   assign step     = cmd.shift_en && shift_todo;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         code_ff  <= req_type;
         value_ff <= req_entry_value;
         index_ff <= req_read_index;
      end
      if (cmd.plan_en) begin
         plan_ff <= plan_in;
         ptr_ff  <= plan_in.up ? count_ff : plan_in.from;
      end else if (step) begin
         ptr_ff <= ptr_next;
      end
      if (step) begin
         wb_addr_ff <= ptr_ff[CSB_ADDR_W-1:0];
      end
   end

   // one read and one write port; write-back lands in the cycle after its read
   always_ff @(posedge clock) begin
      if (wb_valid_ff) begin
         mem[wb_addr_ff] <= rd_ff;
      end else if (cmd.final_en && plan_ff.wr) begin
         mem[plan_ff.wr_addr] <= value_ff;
      end
      if (step) begin
         rd_ff <= mem[src[CSB_ADDR_W-1:0]];
      end else if (cmd.final_en && plan_ff.rd) begin
         rd_ff <= mem[plan_ff.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff  <= 1'b0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= step;
         if (cmd.final_en) begin
            count_ff  <= plan_ff.n_count;
            cursor_ff <= plan_ff.n_cursor;
         end
         if (cmd.rsp_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff  <= plan_ff.rd ? rd_ff : '0;
         rsp_ok_ff     <= plan_ff.ok;
         rsp_cur_ff    <= cursor_ff < count_ff;
         rsp_count_ff  <= count_ff;
         rsp_cursor_ff <= cursor_ff;
      end
   end

   assign status.shift_busy = shift_todo || wb_valid_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_has_current = rsp_cur_ff;
   assign rsp_item_count  = rsp_count_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;

endmodule

// ----- src/cursor_sequence_buffer_top.sv -----
// Top level of the cursor sequence buffer: controller plus datapath.
//
// Ordered list of up to 64 words of 64 bits with an entry count and a cursor.
// Request channel (req_valid/req_ready): one command per transfer, with
// req_type, req_entry_value and req_read_index. Response channel
// (rsp_valid/rsp_ready): exactly one result per command, in order.
// Commands are handled one at a time. A new request can be taken in the
// cycle rsp_valid rises. An insert or remove moves 0 to 63 entries through
// the shift loop, which copies one entry per cycle through the entry memory
// (read, then write back in the next cycle; the shift loop waits for the
// last write-back before the final access).
// The response register frees the request side: a command is taken while
// the previous result still waits; if the receiver stalls, the finished
// command holds in its last step until the response register empties.
// Reset clears count and cursor (empty list) and drops rsp_valid; the entry
// memory is not cleared, since only written positions are ever read.
`timescale 1ns / 1ps

module cursor_sequence_buffer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [csb_pkg::CSB_CODE_W-1:0]   req_type,
   input  logic [csb_pkg::CSB_WORD_W-1:0]   req_entry_value,
   input  logic [csb_pkg::CSB_ADDR_W-1:0]   req_read_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [csb_pkg::CSB_WORD_W-1:0]   rsp_read_value,
   output logic                             rsp_ok,
   output logic                             rsp_has_current,
   output logic [csb_pkg::CSB_CNT_W-1:0]    rsp_item_count,
   output logic [csb_pkg::CSB_CNT_W-1:0]    rsp_cursor_pos
);
   import csb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   csb_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csb_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_entry_value (req_entry_value),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_ok          (rsp_ok),
      .rsp_has_current (rsp_has_current),
      .rsp_item_count  (rsp_item_count),
      .rsp_cursor_pos  (rsp_cursor_pos)
   );

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_pos <= rsp_item_count))
      else $error("cursor beyond item count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item_count <= CSB_CNT_W'(CSB_DEPTH)))
      else $error("item count beyond depth");

   a_current_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_current == (rsp_cursor_pos < rsp_item_count)))
      else $error("has_current disagrees with cursor and count");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in progress");

   a_failed_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_read_value == '0))
      else $error("ignored command returned a nonzero word");

endmodule
